### rtl/core/bsws_pkg.sv
// Shared types and constants for the bounded stack with search.
// No dependencies.
`default_nettype none

package bsws_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int WORD_W         = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_SEARCH = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef struct packed {
        logic              ok;
        logic              found;
        logic [WORD_W-1:0] data;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/bsws_ram.sv
// Entry store for the stack: one write port, one read port, registered read.
// Uses bsws_pkg.
`default_nettype none

module bsws_ram #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);
    import bsws_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/bsws_ctrl.sv
// Sequencer for the stack: fill count, top-down scan with one shared
// comparator, and gap closing for removal. Uses bsws_pkg, drives bsws_ram.
`default_nettype none

module bsws_ctrl #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bsws_pkg::KIND_W-1:0]   kind,
    input  wire logic [bsws_pkg::WORD_W-1:0]   value,
    output logic                               busy,
    output logic                               fin,
    output bsws_pkg::res_t                     res,
    output logic      [CW-1:0]                 cnt_out,
    output logic                               we,
    output logic      [AW-1:0]                 waddr,
    output logic      [DATA_WIDTH-1:0]         wdata,
    output logic      [AW-1:0]                 raddr,
    input  wire logic [DATA_WIDTH-1:0]         rdata
);
    import bsws_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    kind_t                 kind_reg, kind_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;

    kind_t                 kind_in;
    logic [CW-1:0]         cnt_dec;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         ptr_inc2;
    logic [CW-1:0]         ptr_dec;
    logic                  hit;

    assign kind_in  = kind_t'(kind);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign ptr_inc  = ptr_reg + CW'(1);
    assign ptr_inc2 = ptr_reg + CW'(2);
    assign ptr_dec  = ptr_reg - CW'(1);
    assign hit      = (rdata == val_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        kind_next  = kind_reg;
        val_next   = val_reg;
        fin        = 1'b0;
        res        = '0;
        we         = 1'b0;
        waddr      = ptr_reg[AW-1:0];
        wdata      = rdata;
        raddr      = ptr_dec[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_in;
                    val_next  = DATA_WIDTH'(value);
                    ptr_next  = cnt_dec;
                    raddr     = cnt_dec[AW-1:0];
                    case (kind_in)
                        KIND_PUSH:
                        begin
                            fin = 1'b1;
                            if (cnt_reg != DEPTH_C)
                            begin
                                we       = 1'b1;
                                waddr    = cnt_reg[AW-1:0];
                                wdata    = DATA_WIDTH'(value);
                                cnt_next = cnt_reg + CW'(1);
                                res.ok   = 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = cnt_dec;
                                state_next = ST_POP;
                            end
                        end
                        KIND_SEARCH, KIND_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin    = 1'b1;
                                res.ok = (kind_in == KIND_SEARCH);
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            fin      = 1'b1;
                            res.ok   = (cnt_reg != '0);
                            cnt_next = '0;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                fin        = 1'b1;
                res.ok     = 1'b1;
                res.data   = WORD_W'(rdata);
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    if (kind_reg == KIND_SEARCH)
                    begin
                        fin        = 1'b1;
                        res.ok     = 1'b1;
                        res.found  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (ptr_inc == cnt_reg)
                    begin
                        fin        = 1'b1;
                        res.ok     = 1'b1;
                        res.found  = 1'b1;
                        cnt_next   = cnt_dec;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        raddr      = ptr_inc[AW-1:0];
                        state_next = ST_SHIFT;
                    end
                end
                else if (ptr_reg == '0)
                begin
                    fin        = 1'b1;
                    res.ok     = (kind_reg == KIND_SEARCH);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_dec;
                end
            end
            ST_SHIFT:
            begin
                // rdata holds the entry one above ptr; move it down
                we = 1'b1;
                if (ptr_inc2 == cnt_reg)
                begin
                    fin        = 1'b1;
                    res.ok     = 1'b1;
                    res.found  = 1'b1;
                    cnt_next   = cnt_dec;
                    state_next = ST_IDLE;
                end
                else
                begin
                    raddr    = ptr_inc2[AW-1:0];
                    ptr_next = ptr_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            kind_reg  <= KIND_PUSH;
            val_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            kind_reg  <= kind_next;
            val_reg   <= val_next;
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign cnt_out = cnt_next;

endmodule

`default_nettype wire

### rtl/core/bounded_stack_with_search_core.sv
// Push, clear, refused or unknown requests finish from idle; pop reads the top entry in
// a pop state; search scans down from the top; remove scans down, then closes the gap
// (worst case a match at the bottom), as the store's single read port gives one entry per cycle.
// busy is high while a request is in progress; the next word may start in the cycle
// done is shown. The result word is shown for one cycle on done; no receiver stall.
// Reset clears the count, state and result registers; stored words stay unknown until pushed.
`default_nettype none

module bounded_stack_with_search_core #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [bsws_pkg::KIND_W-1:0] kind,
    input  wire logic [bsws_pkg::WORD_W-1:0] value,
    output logic                             done,
    output logic                             ok,
    output logic      [bsws_pkg::WORD_W-1:0] data,
    output logic                             found,
    output logic      [CW-1:0]               count,
    output logic                             empty_res
);
    import bsws_pkg::*;

    logic                  fin;
    res_t                  res;
    logic [CW-1:0]         cnt_out;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [DATA_WIDTH-1:0] rdata;

    logic                  done_reg;
    logic                  ok_reg;
    logic [WORD_W-1:0]     data_reg;
    logic                  found_reg;
    logic [CW-1:0]         count_reg;
    logic                  empty_reg;

    bsws_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .value   (value),
        .busy    (busy),
        .fin     (fin),
        .res     (res),
        .cnt_out (cnt_out),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    bsws_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            data_reg  <= '0;
            found_reg <= 1'b0;
            count_reg <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            done_reg <= fin;
            if (fin)
            begin
                ok_reg    <= res.ok;
                data_reg  <= res.data;
                found_reg <= res.found;
                count_reg <= cnt_out;
                empty_reg <= (cnt_out == '0);
            end
        end
    end

    assign done      = done_reg;
    assign ok        = ok_reg;
    assign data      = data_reg;
    assign found     = found_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;

    a_quick_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_PUSH || kind == KIND_CLEAR)) |=> (done && !busy))
        else $error("push or clear did not finish in one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (count <= CW'(DEPTH)))
        else $error("count above depth");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (ok && data == '0))
        else $error("found without ok or with data");

endmodule

`default_nettype wire

### verif/stack_checker.sv
// Checker for the bounded stack with search: predicts each result word from
// the accepted request words and compares it with the core's output.
// Depends on bsws_pkg.
`timescale 1ns / 1ps

module stack_checker #(
    parameter int DEPTH      = bsws_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bsws_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [bsws_pkg::KIND_W-1:0] kind,
    input  logic [bsws_pkg::WORD_W-1:0] value,
    input  logic                        done,
    input  logic                        ok,
    input  logic [bsws_pkg::WORD_W-1:0] data,
    input  logic                        found,
    input  logic [CW-1:0]               count,
    input  logic                        empty_res,
    output int                          fails,
    output int                          pending
);
    import bsws_pkg::*;

    localparam logic [WORD_W-1:0] WORD_MASK =
        (DATA_WIDTH >= WORD_W) ? '1 : WORD_W'((64'd1 << DATA_WIDTH) - 1);

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] data;
        logic              found;
        logic [CW-1:0]     count;
        logic              empty;
    } stack_res_t;

    logic [WORD_W-1:0] shadow [DEPTH];
    logic [CW-1:0]     shadow_fill;
    stack_res_t        results_q [$];

    initial
    begin
        fails       = 0;
        pending     = 0;
        shadow_fill = '0;
    end

    // position of the topmost entry equal to w, -1 if none
    function automatic int top_match(input logic [WORD_W-1:0] w);
        int pos;
        pos = -1;
        for (int i = 0; i < shadow_fill; i++)
        begin
            if (shadow[i] == w)
                pos = i;
        end
        return pos;
    endfunction

    function automatic stack_res_t stack_request(input logic [KIND_W-1:0] k,
                                                 input logic [WORD_W-1:0] v);
        stack_res_t        r;
        logic [WORD_W-1:0] w;
        int                pos;
        r = '0;
        w = v & WORD_MASK;
        case (k)
            KIND_PUSH:
                if (shadow_fill < DEPTH)
                begin
                    shadow[shadow_fill] = w;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            KIND_POP:
                if (shadow_fill > 0)
                begin
                    shadow_fill--;
                    r.data = shadow[shadow_fill];
                    r.ok   = 1'b1;
                end
            KIND_SEARCH:
            begin
                r.found = (top_match(w) >= 0);
                r.ok    = 1'b1;
            end
            KIND_REMOVE:
            begin
                pos = top_match(w);
                if (pos >= 0)
                begin
                    for (int j = pos; j + 1 < shadow_fill; j++)
                        shadow[j] = shadow[j + 1];
                    shadow_fill--;
                    r.found = 1'b1;
                    r.ok    = 1'b1;
                end
            end
            KIND_CLEAR:
                if (shadow_fill > 0)
                begin
                    shadow_fill = '0;
                    r.ok        = 1'b1;
                end
            default: ;
        endcase
        r.count = shadow_fill;
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_res_t want;
        if (!rst_n)
        begin
            results_q.delete();
            shadow_fill = '0;
            pending     = 0;
        end
        else
        begin
            if (done)
            begin
                if (results_q.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual ok %b data %h",
                             $time, ok, data);
                    fails++;
                end
                else
                begin
                    want = results_q.pop_front();
                    if (ok !== want.ok)
                        note_mismatch("ok", want.ok, ok);
                    if (data !== want.data)
                        note_mismatch("data", want.data, data);
                    if (found !== want.found)
                        note_mismatch("found", want.found, found);
                    if (count !== want.count)
                        note_mismatch("count", want.count, count);
                    if (empty_res !== want.empty)
                        note_mismatch("empty_res", want.empty, empty_res);
                end
            end
            if (start && !busy)
                results_q.push_back(stack_request(kind, value));
            pending = results_q.size();
        end
    end

endmodule

### verif/tb.sv
// Testbench top for bounded_stack_with_search_core: drives request words,
// applies random idling and gives the verdict. Depends on bsws_pkg and
// stack_checker.
`timescale 1ns / 1ps

module tb;
    import bsws_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int NUM_WORDS   = 900;
    localparam int STALL_LIMIT = 2000;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_CLEAR + 1);
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic              done;
    logic              ok;
    logic [WORD_W-1:0] data;
    logic              found;
    logic [CW-1:0]     count;
    logic              empty_res;
    int                fails;
    int                pending;

    bit                idle_en;
    int                stall_cycles;
    logic [WORD_W-1:0] pool [8];

    bounded_stack_with_search_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .done      (done),
        .ok        (ok),
        .data      (data),
        .found     (found),
        .count     (count),
        .empty_res (empty_res)
    );

    stack_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .done      (done),
        .ok        (ok),
        .data      (data),
        .found     (found),
        .count     (count),
        .empty_res (empty_res),
        .fails     (fails),
        .pending   (pending)
    );

    initial
        clk = 1'b0;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // busy is stable at the falling edge, so a word driven here is taken
    // at the next rising edge
    task automatic issue(input logic [KIND_W-1:0] k, input logic [WORD_W-1:0] v);
        bit sent;
        sent = 1'b0;
        while (!sent)
        begin
            @(negedge clk);
            if (busy || (idle_en && $urandom_range(0, 99) < 10))
                start <= 1'b0;
            else
            begin
                start <= 1'b1;
                kind  <= k;
                value <= v;
                sent = 1'b1;
            end
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 80)
            return pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    initial
    begin : stim
        int                issued;
        int                seg_len;
        int                push_w;
        int                r;
        logic [KIND_W-1:0] k;

        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = KIND_PUSH;
        value        = '0;
        idle_en      = 1'b1;
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h0000_0001;
        for (int i = 4; i < 8; i++)
            pool[i] = $urandom();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // empty store corner cases
        issue(KIND_CLEAR, '0);
        issue(KIND_POP, '0);
        issue(KIND_SEARCH, '0);
        issue(KIND_REMOVE, '0);
        for (int u = KIND_UNUSED_LO; u <= KIND_UNUSED_HI; u++)
            issue(KIND_W'(u), '1);
        // duplicates, extremes, removal from the middle with gap close
        issue(KIND_PUSH, '0);
        issue(KIND_PUSH, '1);
        issue(KIND_PUSH, '0);
        issue(KIND_PUSH, 32'h1234_5678);
        issue(KIND_SEARCH, '1);
        issue(KIND_SEARCH, 32'hDEAD_BEEF);
        issue(KIND_REMOVE, '0);
        issue(KIND_REMOVE, 32'hDEAD_BEEF);
        issue(KIND_REMOVE, 32'h1234_5678);
        issue(KIND_POP, '0);
        issue(KIND_POP, '0);
        issue(KIND_PUSH, 32'h5555_5555);
        issue(KIND_PUSH, 32'hAAAA_AAAA);
        issue(KIND_REMOVE, 32'h5555_5555);
        issue(KIND_CLEAR, '0);

        // random segments are each weighted toward filling, balancing or draining the store
        issued = 0;
        while (issued < NUM_WORDS)
        begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_w = 85;
                1: push_w = 50;
                default: push_w = 15;
            endcase
            for (int n = 0; n < seg_len; n++)
            begin
                idle_en = !(issued >= 400 && issued < 600);
                if ($urandom_range(0, 99) < push_w)
                    k = KIND_PUSH;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        k = KIND_POP;
                    else if (r < 65)
                        k = KIND_SEARCH;
                    else if (r < 92)
                        k = KIND_REMOVE;
                    else if (r < 97)
                        k = KIND_CLEAR;
                    else
                        k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                end
                issue(k, pick_value());
                issued++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DEPTH + 4) @(negedge clk);

        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/bsws_pkg.sv
rtl/core/bsws_ram.sv
rtl/core/bsws_ctrl.sv
rtl/core/bounded_stack_with_search_core.sv
verif/stack_checker.sv
verif/tb.sv
